### rtl/hwt_pkg.sv
// ----------------------------------------------------------------------------
// hwt_pkg
// Shared types and constants of the hashed timer wheel.
// ----------------------------------------------------------------------------
`default_nettype none

package hwt_pkg;

  // Default sizes of the wheel and of the timer pool
  localparam int SLOTS_DEF  = 256;
  localparam int TIMERS_DEF = 64;

  // Fixed field widths
  localparam int ID_W   = 16;
  localparam int IV_W   = 16;
  localparam int EV_W   = 2;
  localparam int TIME_W = 8;
  localparam int SC_W   = 9;
  localparam int XW     = IV_W + 1;   // interval plus current slot, before reduction
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [SC_W-1:0] SLOT_COUNT_RST = SC_W'(100);

  // Register index decoded from paddr[2]
  localparam logic REG_SLOT_COUNT = 1'b0;

  // Command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Result event codes
  typedef enum logic [EV_W-1:0] {
    EV_STARTED  = 2'd0,
    EV_REJECTED = 2'd1,
    EV_EXPIRED  = 2'd2
  } event_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REJ,
    ST_MOD,
    ST_SRD,
    ST_SLOT,
    ST_TRD,
    ST_THEAD,
    ST_ERD,
    ST_EMIT
  } state_t;

  // Request to the serial modulo unit
  typedef struct packed {
    logic          go;
    logic [XW-1:0] x;
  } mod_req_t;

endpackage

`default_nettype wire

### rtl/hwt_if.sv
// ----------------------------------------------------------------------------
// hwt_in_if / hwt_out_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hwt_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [hwt_pkg::IV_W-1:0]  interval;
  logic [hwt_pkg::ID_W-1:0]  request_id;

  modport source (output valid, command, interval, request_id, input ready);
  modport sink   (input valid, command, interval, request_id, output ready);
endinterface

interface hwt_out_if;
  logic                        valid;
  logic                        ready;
  logic [hwt_pkg::EV_W-1:0]    event_res;
  logic [hwt_pkg::ID_W-1:0]    expired_id;
  logic [hwt_pkg::TIME_W-1:0]  slot_time;
  logic                        last;

  modport source (output valid, event_res, expired_id, slot_time, last, input ready);
  modport sink   (input valid, event_res, expired_id, slot_time, last, output ready);
endinterface

`default_nettype wire

### rtl/hashed_timer_wheel_top.sv
// ----------------------------------------------------------------------------
// hashed_timer_wheel_top
// Single-level timing wheel with a fixed timer pool and an APB slot count.
// ----------------------------------------------------------------------------
// After reset the block empties every slot of the slot head memory and takes no
// command word in that time (register writes are taken). One command is handled
// at a time. A start runs the 17-step serial remainder that finds the target
// slot, then reads and writes back the slot head and entry memories, and returns
// one word: accepted, or rejected without those steps when all TIMERS entries
// are in use. A tick reads and empties the slot head, then does one read and one
// write-back of the entry memory per expired timer, and returns one word per
// expired timer, newest first, with last set on the final one; an empty slot
// returns nothing. A held result does not block the next command until another
// result has to be loaded. Write the slot count only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_timer_wheel_top #(
  parameter int SLOTS  = hwt_pkg::SLOTS_DEF,
  parameter int TIMERS = hwt_pkg::TIMERS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  hwt_in_if.sink                           in_if,
  hwt_out_if.source                        out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hwt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [hwt_pkg::DATA_W-1:0]  pwdata,
  output logic      [hwt_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int NW = $clog2(SLOTS + 1);

  logic [NW-1:0]      n;
  hwt_pkg::mod_req_t  mod_req;
  logic               mod_done;
  logic [NW-1:0]      mod_rem;

  // configuration registers
  hwt_cfg #(.SLOTS(SLOTS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n       (n)
  );

  // slot index reduction
  hwt_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .n     (n),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  // wheel sequencer and memories
  hwt_ctrl #(.SLOTS(SLOTS), .TIMERS(TIMERS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .n        (n),
    .mod_req  (mod_req),
    .mod_done (mod_done),
    .mod_rem  (mod_rem)
  );

endmodule

`default_nettype wire

### rtl/hwt_cfg.sv
// ----------------------------------------------------------------------------
// hwt_cfg
// APB register file: slot count register and the clamped slot count in use.
// ----------------------------------------------------------------------------
`default_nettype none

module hwt_cfg #(
  parameter int SLOTS = hwt_pkg::SLOTS_DEF,
  localparam int NW   = $clog2(SLOTS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [hwt_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [hwt_pkg::DATA_W-1:0]  pwdata,
  output logic      [hwt_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [NW-1:0]               n
);

  localparam int CW = (NW > hwt_pkg::SC_W) ? NW : hwt_pkg::SC_W;

  logic [hwt_pkg::SC_W-1:0] slot_count_r;
  logic                     wr_hit;
  logic [CW-1:0]            sc_ext;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & (paddr[2] == hwt_pkg::REG_SLOT_COUNT);

  // slot count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= hwt_pkg::SLOT_COUNT_RST;
    end else if (wr_hit) begin
      slot_count_r <= pwdata[hwt_pkg::SC_W-1:0];
    end
  end

  // read back
  assign prdata = (paddr[2] == hwt_pkg::REG_SLOT_COUNT) ?
                  hwt_pkg::DATA_W'(slot_count_r) : '0;

  // clamp to 1..SLOTS
  assign sc_ext = CW'(slot_count_r);
  always_comb begin
    if (sc_ext == '0) begin
      n = NW'(1);
    end else if (sc_ext > CW'(SLOTS)) begin
      n = NW'(SLOTS);
    end else begin
      n = NW'(sc_ext);
    end
  end

endmodule

`default_nettype wire

### rtl/hwt_mod.sv
// ----------------------------------------------------------------------------
// hwt_mod
// Bit-serial remainder unit: x mod n, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hwt_mod #(
  parameter int SLOTS = hwt_pkg::SLOTS_DEF,
  localparam int NW   = $clog2(SLOTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hwt_pkg::mod_req_t req,
  input  wire logic [NW-1:0]     n,
  output logic                   done,
  output logic      [NW-1:0]     rem
);

  localparam int XW    = hwt_pkg::XW;
  localparam int CNT_W = $clog2(XW + 1);

  logic [XW-1:0]    x_r;
  logic [NW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [NW:0]      trial;
  logic [NW:0]      trial_sub;

  // shift in the next dividend bit and subtract n when it fits
  assign trial     = {rem_r, x_r[XW-1]};
  assign trial_sub = trial - {1'b0, n};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(XW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      x_r   <= req.x;
      rem_r <= '0;
    end else if (busy_r) begin
      x_r   <= {x_r[XW-2:0], 1'b0};
      rem_r <= (trial >= {1'b0, n}) ? trial_sub[NW-1:0] : trial[NW-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < n))
    else $error("remainder not below slot count");

endmodule

`default_nettype wire

### rtl/hwt_ctrl.sv
// ----------------------------------------------------------------------------
// hwt_ctrl
// Wheel sequencer: slot head memory, timer entry memory, free list and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hwt_ctrl #(
  parameter int SLOTS  = hwt_pkg::SLOTS_DEF,
  parameter int TIMERS = hwt_pkg::TIMERS_DEF,
  localparam int NW    = $clog2(SLOTS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  hwt_in_if.sink                  in_if,
  hwt_out_if.source               out_if,
  input  wire logic [NW-1:0]      n,
  output hwt_pkg::mod_req_t       mod_req,
  input  wire logic               mod_done,
  input  wire logic [NW-1:0]      mod_rem
);

  localparam int SW   = $clog2(SLOTS);
  localparam int EW   = $clog2(TIMERS + 1);
  localparam int IW   = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int ID_W = hwt_pkg::ID_W;
  localparam int XW   = hwt_pkg::XW;
  localparam logic [EW-1:0] NIL = EW'(TIMERS);

  // state and bookkeeping
  hwt_pkg::state_t   state_r, state_nxt;
  logic [SW-1:0]     current_r, current_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;
  logic [EW-1:0]     cur_r, cur_nxt;
  logic [EW-1:0]     free_head_r, free_head_nxt;
  logic [EW-1:0]     alloc_cnt_r, alloc_cnt_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;

  // result register
  logic                      out_valid_r, out_valid_nxt;
  hwt_pkg::event_t           out_res_r, out_res_nxt;
  logic [ID_W-1:0]           out_id_r, out_id_nxt;
  logic [SW-1:0]             out_time_r, out_time_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_free;

  // slot head memory
  logic [EW-1:0]     head_mem [SLOTS];
  logic [EW-1:0]     head_rd_r;
  logic [SW-1:0]     head_raddr, head_waddr;
  logic [EW-1:0]     head_wdata;
  logic              head_we;

  // timer entry memory: {next, id}
  logic [EW+ID_W-1:0] ent_mem [TIMERS];
  logic [EW+ID_W-1:0] ent_rd_r;
  logic [IW-1:0]      ent_raddr, ent_waddr;
  logic [EW+ID_W-1:0] ent_wdata;
  logic               ent_we;
  logic [EW-1:0]      ent_next;
  logic [ID_W-1:0]    ent_id;

  logic              pool_full;
  logic              fresh;
  logic [EW-1:0]     new_e;
  logic [NW:0]       cur_inc;
  logic [SW-1:0]     current_wrap;

  assign ent_next  = ent_rd_r[EW+ID_W-1:ID_W];
  assign ent_id    = ent_rd_r[ID_W-1:0];
  assign pool_full = (alloc_cnt_r == NIL) && (free_head_r == NIL);
  assign fresh     = (alloc_cnt_r != NIL);
  assign new_e     = fresh ? alloc_cnt_r : free_head_r;
  assign out_free  = !out_valid_r || out_if.ready;

  // tick advance with wrap at the slot count
  assign cur_inc      = (NW+1)'(current_r) + (NW+1)'(1);
  assign current_wrap = (cur_inc >= {1'b0, n}) ? '0 : cur_inc[SW-1:0];

  assign in_if.ready       = (state_r == hwt_pkg::ST_IDLE);
  assign out_if.valid      = out_valid_r;
  assign out_if.event_res  = out_res_r;
  assign out_if.expired_id = out_id_r;
  assign out_if.slot_time  = hwt_pkg::TIME_W'(out_time_r);
  assign out_if.last       = out_last_r;

  // memories
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_rd_r <= head_mem[head_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rd_r <= ent_mem[ent_raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hwt_pkg::ST_CLEAR;
      current_r   <= '0;
      clr_r       <= '0;
      free_head_r <= NIL;
      alloc_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      current_r   <= current_nxt;
      clr_r       <= clr_nxt;
      free_head_r <= free_head_nxt;
      alloc_cnt_r <= alloc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    cur_r      <= cur_nxt;
    id_r       <= id_nxt;
    out_res_r  <= out_res_nxt;
    out_id_r   <= out_id_nxt;
    out_time_r <= out_time_nxt;
    out_last_r <= out_last_nxt;
  end

  // next state and memory control
  always_comb begin
    state_nxt     = state_r;
    current_nxt   = current_r;
    slot_nxt      = slot_r;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    free_head_nxt = free_head_r;
    alloc_cnt_nxt = alloc_cnt_r;
    id_nxt        = id_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_res_nxt   = out_res_r;
    out_id_nxt    = out_id_r;
    out_time_nxt  = out_time_r;
    out_last_nxt  = out_last_r;
    head_raddr    = slot_r;
    head_we       = 1'b0;
    head_waddr    = slot_r;
    head_wdata    = NIL;
    ent_raddr     = free_head_r[IW-1:0];
    ent_we        = 1'b0;
    ent_waddr     = new_e[IW-1:0];
    ent_wdata     = {head_rd_r, id_r};
    mod_req.go    = 1'b0;
    mod_req.x     = XW'(in_if.interval) + XW'(current_r);

    case (state_r)
      // empty every slot after reset
      hwt_pkg::ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
        clr_nxt    = clr_r + SW'(1);
        if (clr_r == SW'(SLOTS - 1)) begin
          state_nxt = hwt_pkg::ST_IDLE;
        end
      end

      hwt_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          id_nxt = in_if.request_id;
          if (in_if.command == hwt_pkg::CMD_TICK) begin
            current_nxt = current_wrap;
            state_nxt   = hwt_pkg::ST_TRD;
          end else if (pool_full) begin
            state_nxt = hwt_pkg::ST_REJ;
          end else begin
            mod_req.go = 1'b1;
            state_nxt  = hwt_pkg::ST_MOD;
          end
        end
      end

      hwt_pkg::ST_REJ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = hwt_pkg::EV_REJECTED;
          out_id_nxt    = id_r;
          out_time_nxt  = current_r;
          out_last_nxt  = 1'b1;
          state_nxt     = hwt_pkg::ST_IDLE;
        end
      end

      // wait for the target slot
      hwt_pkg::ST_MOD: begin
        if (mod_done) begin
          slot_nxt  = mod_rem[SW-1:0];
          state_nxt = hwt_pkg::ST_SRD;
        end
      end

      // slot head and free list head are being read
      hwt_pkg::ST_SRD: begin
        state_nxt = hwt_pkg::ST_SLOT;
      end

      // link the new entry at the head of the slot
      hwt_pkg::ST_SLOT: begin
        if (out_free) begin
          if (fresh) begin
            alloc_cnt_nxt = alloc_cnt_r + EW'(1);
          end else begin
            free_head_nxt = ent_next;
          end
          ent_we        = 1'b1;
          head_we       = 1'b1;
          head_wdata    = new_e;
          out_valid_nxt = 1'b1;
          out_res_nxt   = hwt_pkg::EV_STARTED;
          out_id_nxt    = id_r;
          out_time_nxt  = current_r;
          out_last_nxt  = 1'b1;
          state_nxt     = hwt_pkg::ST_IDLE;
        end
      end

      hwt_pkg::ST_TRD: begin
        head_raddr = current_r;
        state_nxt  = hwt_pkg::ST_THEAD;
      end

      // take the slot list and empty the slot
      hwt_pkg::ST_THEAD: begin
        head_raddr = current_r;
        head_we    = 1'b1;
        head_waddr = current_r;
        cur_nxt    = head_rd_r;
        state_nxt  = (head_rd_r == NIL) ? hwt_pkg::ST_IDLE : hwt_pkg::ST_ERD;
      end

      hwt_pkg::ST_ERD: begin
        ent_raddr = cur_r[IW-1:0];
        state_nxt = hwt_pkg::ST_EMIT;
      end

      // report one expired timer and push its entry on the free list
      hwt_pkg::ST_EMIT: begin
        ent_raddr = cur_r[IW-1:0];
        if (out_free) begin
          ent_we        = 1'b1;
          ent_waddr     = cur_r[IW-1:0];
          ent_wdata     = {free_head_r, ent_id};
          free_head_nxt = cur_r;
          cur_nxt       = ent_next;
          out_valid_nxt = 1'b1;
          out_res_nxt   = hwt_pkg::EV_EXPIRED;
          out_id_nxt    = ent_id;
          out_time_nxt  = current_r;
          out_last_nxt  = (ent_next == NIL);
          state_nxt     = (ent_next == NIL) ? hwt_pkg::ST_IDLE : hwt_pkg::ST_ERD;
        end
      end

      default: begin
        state_nxt = hwt_pkg::ST_IDLE;
      end
    endcase
  end

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, current_r} < (SW+1)'(SLOTS))
    else $error("current slot out of range");

  a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_cnt_r <= NIL)
    else $error("fresh entry count beyond pool size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> (state_r != hwt_pkg::ST_IDLE))
    else $error("sequencer idle right after accepting a word");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hwt_pkg::ST_REJ) |-> pool_full)
    else $error("reject with a free entry");

endmodule

`default_nettype wire

### tb/tb_hashed_timer_wheel_top.sv
// ----------------------------------------------------------------------------
// tb_hashed_timer_wheel_top
// Self-checking bench for the single-level timing wheel. Start and tick
// command words go in over a valid/ready channel. A wheel model inside the
// bench (slot lists, timer pool, current slot) predicts every result word,
// and the result words are checked in order against it. The APB slot count
// is rewritten between phases: reset value, clamped extremes, shrinking with
// timers pending, a full pool at one slot, and random traffic at several
// wheel sizes. Both channel sides idle at random.
// ----------------------------------------------------------------------------
module tb_hashed_timer_wheel_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = hwt_pkg::SLOTS_DEF;
  localparam int TIMERS        = hwt_pkg::TIMERS_DEF;
  localparam int ADDR_W        = hwt_pkg::ADDR_W;
  localparam int DATA_W        = hwt_pkg::DATA_W;
  localparam int ID_W          = hwt_pkg::ID_W;
  localparam int IV_W          = hwt_pkg::IV_W;
  localparam int TIME_W        = hwt_pkg::TIME_W;
  localparam int SC_W          = hwt_pkg::SC_W;
  localparam int NIL_ENTRY     = TIMERS;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [ADDR_W-1:0] SLOT_COUNT_ADDR = {hwt_pkg::REG_SLOT_COUNT, 2'b00};

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  hwt_in_if  in_ch ();
  hwt_out_if out_ch ();

  hashed_timer_wheel_top #(
    .SLOTS  (SLOTS),
    .TIMERS (TIMERS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // One predicted result word
  typedef struct packed {
    hwt_pkg::event_t     ev;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   slot;
    logic                last;
  } timer_event_t;

  timer_event_t pending_events[$];

  // Wheel model state
  logic [SC_W-1:0] wheel_slot_count;
  int unsigned     wheel_cur;
  int unsigned     slot_first[SLOTS];
  int unsigned     entry_link[TIMERS];
  logic [ID_W-1:0] entry_tag[TIMERS];
  bit              entry_busy[TIMERS];

  // Run statistics
  int unsigned cycle_count = 0;
  int unsigned n_words     = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_results   = 0;
  int unsigned n_expired   = 0;
  int unsigned n_rejected  = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_fail      = 0;
  bit          gaps_on     = 1'b1;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d result words outstanding", $time,
               cycle_count, pending_events.size());
      $display("tb_hashed_timer_wheel_top: FAIL");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Interval: full 16-bit range or up to two wheel turns
  function automatic logic [IV_W-1:0] rand_iv(int unsigned n);
    if ($urandom_range(0, 99) < 40) return IV_W'($urandom());
    return IV_W'($urandom_range(0, 2 * n));
  endfunction

  function automatic int unsigned timers_armed();
    int unsigned cnt;
    cnt = 0;
    for (int i = 0; i < TIMERS; i++) if (entry_busy[i]) cnt++;
    return cnt;
  endfunction

  // Wheel model: apply one accepted command word, queue its result words
  function automatic void wheel_apply(logic cmd, logic [IV_W-1:0] iv, logic [ID_W-1:0] id);
    int unsigned  n, e, slot, p, nxt;
    timer_event_t r;
    n = (wheel_slot_count < 1) ? 1 : ((wheel_slot_count > SLOTS) ? SLOTS : wheel_slot_count);
    if (cmd == hwt_pkg::CMD_START) begin
      // lowest free entry; none left means reject
      e = 0;
      while (e < TIMERS && entry_busy[e]) e++;
      if (e == TIMERS) begin
        r.ev = hwt_pkg::EV_REJECTED;
      end else begin
        slot = (wheel_cur + iv % n) % n;
        entry_busy[e] = 1'b1;
        entry_tag[e]  = id;
        entry_link[e] = slot_first[slot];
        slot_first[slot] = e;
        r.ev = hwt_pkg::EV_STARTED;
      end
      r.id   = id;
      r.slot = wheel_cur[TIME_W-1:0];
      r.last = 1'b1;
      pending_events.push_back(r);
    end else begin
      // advance first, then drain the new slot newest first
      wheel_cur = (wheel_cur + 1 >= n) ? 0 : wheel_cur + 1;
      p = slot_first[wheel_cur];
      while (p != NIL_ENTRY) begin
        nxt    = entry_link[p];
        r.ev   = hwt_pkg::EV_EXPIRED;
        r.id   = entry_tag[p];
        r.slot = wheel_cur[TIME_W-1:0];
        r.last = (nxt == NIL_ENTRY);
        entry_busy[p] = 1'b0;
        pending_events.push_back(r);
        p = nxt;
      end
      slot_first[wheel_cur] = NIL_ENTRY;
    end
  endfunction

  // Result side: random back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (gaps_on && $urandom_range(0, 99) < 30) begin
        out_ch.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker: each accepted word against the oldest prediction
  always @(posedge clk) begin
    timer_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result word: ev=%0d id=%h slot=%0d last=%b", $time,
                 out_ch.event_res, out_ch.expired_id, out_ch.slot_time, out_ch.last);
        n_fail++;
      end else begin
        want = pending_events.pop_front();
        n_results++;
        if (want.ev == hwt_pkg::EV_EXPIRED) n_expired++;
        if (want.ev == hwt_pkg::EV_REJECTED) n_rejected++;
        if (out_ch.event_res !== want.ev) begin
          $display("%0t: event_res mismatch: expected %0d, got %0d", $time,
                   want.ev, out_ch.event_res);
          n_fail++;
        end
        if (out_ch.expired_id !== want.id) begin
          $display("%0t: expired_id mismatch: expected %h, got %h", $time,
                   want.id, out_ch.expired_id);
          n_fail++;
        end
        if (out_ch.slot_time !== want.slot) begin
          $display("%0t: slot_time mismatch: expected %0d, got %0d", $time,
                   want.slot, out_ch.slot_time);
          n_fail++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last mismatch: expected %b, got %b", $time, want.last, out_ch.last);
          n_fail++;
        end
      end
    end
  end

  // Send one command word and predict its results on acceptance
  task automatic issue_command(input logic cmd, input logic [IV_W-1:0] iv,
                               input logic [ID_W-1:0] id);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.interval   <= iv;
    in_ch.request_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    wheel_apply(cmd, iv, id);
    n_words++;
    if (cmd == hwt_pkg::CMD_TICK) n_ticks++;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Tick with junk in the unused fields
  task automatic tick_wheel();
    issue_command(hwt_pkg::CMD_TICK, IV_W'($urandom()), ID_W'($urandom()));
  endtask

  // Hold off input until every predicted word is out, then let a tick on
  // an empty slot finish
  task automatic wait_wheel_idle();
    in_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the slot count; the bus goes idle after the access
  task automatic write_slot_count(input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SLOT_COUNT_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    wheel_slot_count = data[SC_W-1:0];
    n_cfg++;
    @(posedge clk);
  endtask

  // APB read of the slot count, compared with the reset value or the last value written
  task automatic verify_slot_count();
    logic [DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= SLOT_COUNT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (rd[SC_W-1:0] !== wheel_slot_count) begin
      $display("%0t: slot_count readback mismatch: expected %0d, got %0d", $time,
               wheel_slot_count, rd[SC_W-1:0]);
      n_fail++;
    end
  endtask

  // Empty the pool: full-size wheel, tick until nothing is armed
  task automatic flush_wheel();
    wait_wheel_idle();
    write_slot_count(SLOTS);
    while (timers_armed() != 0) tick_wheel();
    wait_wheel_idle();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_register_reset();
    verify_slot_count();
  endtask

  // Small wheel: extreme fields, shared slot, empty ticks, wrap
  task automatic test_basic_wheel();
    wait_wheel_idle();
    write_slot_count(4);
    issue_command(hwt_pkg::CMD_START, 16'h0000, 16'h0000);   // lands on the current slot
    issue_command(hwt_pkg::CMD_START, 16'hFFFF, 16'hFFFF);
    issue_command(hwt_pkg::CMD_START, 16'h0001, 16'h1234);
    issue_command(hwt_pkg::CMD_START, 16'h0005, 16'hA5A5);   // same slot, newer
    issue_command(hwt_pkg::CMD_START, 16'h0004, 16'h5A5A);   // multiple of the wheel size
    repeat (5) tick_wheel();
    wait_wheel_idle();
  endtask

  // Slot count below and above range, masking of the upper write bits
  task automatic test_slot_count_clamp();
    wait_wheel_idle();
    write_slot_count(0);
    verify_slot_count();
    issue_command(hwt_pkg::CMD_START, 16'hFFFF, 16'h8001);
    issue_command(hwt_pkg::CMD_START, 16'h0007, 16'h7FFE);
    tick_wheel();
    tick_wheel();
    wait_wheel_idle();
    write_slot_count(511);
    verify_slot_count();
    issue_command(hwt_pkg::CMD_START, 16'd258, 16'h0F0F);
    repeat (3) tick_wheel();
    wait_wheel_idle();
    write_slot_count(257);
    verify_slot_count();
    issue_command(hwt_pkg::CMD_START, 16'd258, 16'hF0F0);
    repeat (3) tick_wheel();
    wait_wheel_idle();
    write_slot_count(32'hFFFF_FE05);
    verify_slot_count();
  endtask

  // Shrink the wheel under armed timers and the current slot, then grow it
  task automatic test_resize_with_pending();
    wait_wheel_idle();
    write_slot_count(16);
    while (wheel_cur != 10) tick_wheel();
    issue_command(hwt_pkg::CMD_START, 16'd3, 16'hC3C3);
    issue_command(hwt_pkg::CMD_START, 16'd16, 16'h3C3C);
    wait_wheel_idle();
    write_slot_count(8);              // current slot now beyond the wheel
    repeat (9) tick_wheel();
    wait_wheel_idle();
    write_slot_count(16);
    while (wheel_cur != 13) tick_wheel();
    wait_wheel_idle();
  endtask

  // One-slot wheel: fill the pool, get rejects, expire all in one tick
  task automatic test_pool_exhaustion();
    flush_wheel();
    write_slot_count(1);
    repeat (TIMERS + 3) issue_command(hwt_pkg::CMD_START, rand_iv(1), ID_W'($urandom()));
    tick_wheel();
    tick_wheel();
    wait_wheel_idle();
  endtask

  // Mixed traffic at several wheel sizes
  task automatic test_random_traffic();
    int unsigned phase_slots[6];
    int unsigned n;
    phase_slots = '{2, 3, 7, 13, 256, 0};
    for (int ph = 0; ph < 6; ph++) begin
      n = (phase_slots[ph] == 0) ? $urandom_range(1, 40) : phase_slots[ph];
      wait_wheel_idle();
      write_slot_count(($urandom() & ~32'h1FF) | n);
      gaps_on = (ph != 3);
      for (int k = 0; k < 8; k++) begin
        if (ph == 1 && k == 4) wait_wheel_idle();
        if ($urandom_range(0, 99) < 40) tick_wheel();
        else issue_command(hwt_pkg::CMD_START, rand_iv(n), ID_W'($urandom()));
      end
    end
    gaps_on = 1'b1;
    wait_wheel_idle();
  endtask

  // ---------------------------------------------------------------- main
  initial begin
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= hwt_pkg::CMD_START;
    in_ch.interval   <= '0;
    in_ch.request_id <= '0;
    wheel_slot_count = hwt_pkg::SLOT_COUNT_RST;
    wheel_cur        = 0;
    for (int i = 0; i < SLOTS; i++) slot_first[i] = NIL_ENTRY;
    for (int i = 0; i < TIMERS; i++) begin
      entry_link[i] = 0;
      entry_tag[i]  = '0;
      entry_busy[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_reset();
    test_basic_wheel();
    test_slot_count_clamp();
    test_resize_with_pending();
    test_pool_exhaustion();
    test_random_traffic();
    wait_wheel_idle();

    $display("Sent %0d command words (%0d ticks) over %0d slot count writes.",
             n_words, n_ticks, n_cfg);
    $display("Checked %0d result words: %0d expiries, %0d rejects, %0d timers left armed.",
             n_results, n_expired, n_rejected, timers_armed());
    if (n_fail == 0 && pending_events.size() == 0) begin
      $display("tb_hashed_timer_wheel_top: PASS");
    end else begin
      $display("%0d mismatches, %0d result words never arrived", n_fail, pending_events.size());
      $display("tb_hashed_timer_wheel_top: FAIL");
    end
    $finish;
  end

endmodule
